// ===== rtl/fte_pkg.sv =====
package fte_pkg;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_CHAIN = 2'd2;

  localparam logic [11:0] END_MARK = 12'hff8;
  localparam logic [12:0] CNT_CAP  = 13'd4096;

  localparam logic [2:0] ADDR_TABLE_SECTORS = 3'd0;
  localparam logic [3:0] TABLE_SECTORS_RST  = 4'd8;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_LINK,
    S_FINISH
  } fte_state_e;

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       rd0;
    logic       rd1;
    logic       lat_b1;
    logic       set_value;
    logic       wr0;
    logic       wr1;
    logic       step;
    logic       set_status;
    logic [1:0] status;
    logic       out_load;
  } fte_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       in_range;
    logic       below_limit;
    logic       end_mark;
    logic       clr_last;
  } fte_sts_t;

endpackage

// ===== rtl/fte_ram.sv =====
module fte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fte_ctrl.sv =====
module fte_ctrl import fte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  input  fte_sts_t sts_i,
  output fte_cmd_t cmd_o
);

  fte_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.req == REQ_NONE) begin
          state_d = S_FINISH;
        end else if (sts_i.req == REQ_FREE && !sts_i.below_limit) begin
          state_d = S_FINISH;
        end else if (!sts_i.in_range) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_RD0;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_RD2;
      S_RD2: begin
        state_d = (sts_i.req == REQ_READ) ? S_FINISH : S_WR0;
      end
      S_WR0: state_d = S_WR1;
      S_WR1: begin
        state_d = (sts_i.req == REQ_FREE) ? S_LINK : S_FINISH;
      end
      S_LINK: begin
        state_d = sts_i.end_mark ? S_FINISH : S_CHECK;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_CHECK: begin
        if (sts_i.req == REQ_NONE) begin
          cmd_o.set_status = 1'b0;
        end else if (sts_i.req == REQ_FREE && !sts_i.below_limit) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_CHAIN;
        end else if (!sts_i.in_range) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_RANGE;
        end
      end
      S_RD0: cmd_o.rd0 = 1'b1;
      S_RD1: cmd_o.rd1 = 1'b1;
      S_RD2: begin
        cmd_o.lat_b1    = 1'b1;
        cmd_o.set_value = (sts_i.req == REQ_READ);
      end
      S_WR0:    cmd_o.wr0      = 1'b1;
      S_WR1:    cmd_o.wr1      = 1'b1;
      S_LINK:   cmd_o.step     = 1'b1;
      S_FINISH: cmd_o.out_load = out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/fte_datapath.sv =====
module fte_datapath import fte_pkg::*; #(
  parameter int SECTOR_BYTES = 512,
  parameter int MAX_SECTORS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  table_sectors_i,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] cluster_i,
  input  logic [11:0] code_i,
  input  fte_cmd_t    cmd_i,
  output fte_sts_t    sts_o,
  output logic [11:0] entry_value_o,
  output logic [1:0]  status_o,
  output logic [11:0] freed_count_o
);

  localparam int StoreBytes = SECTOR_BYTES * MAX_SECTORS;
  localparam int AW  = $clog2(StoreBytes);
  localparam int LW  = $clog2(StoreBytes + 1);
  localparam int XW  = (AW > 13) ? AW : 13;
  localparam int CW  = (XW + 1 > LW) ? XW + 1 : LW;
  localparam int SIW = $clog2(MAX_SECTORS + 1);

  logic [LW-1:0] len_tab [MAX_SECTORS+1];
  logic [12:0]   cnt_tab [MAX_SECTORS+1];

  for (genvar s = 0; s <= MAX_SECTORS; s++) begin : g_tab
    localparam int Len  = s * SECTOR_BYTES;
    localparam int Even = (Len >= 2) ? ((Len - 2) / 3 + 1) : 0;
    localparam int Odd  = (Len >= 3) ? ((Len - 3) / 3 + 1) : 0;
    localparam int Cnt  = (Even + Odd > 4096) ? 4096 : Even + Odd;
    assign len_tab[s] = LW'(Len);
    assign cnt_tab[s] = 13'(Cnt);
  end

  logic [1:0]   req_q;
  logic [11:0]  cur_q, code_q, old_q, value_q;
  logic [7:0]   b0_q, b1_q;
  logic [1:0]   status_q;
  logic [12:0]  freed_q;
  logic [11:0]  ev_q, fc_q;
  logic [1:0]   st_q;
  logic [AW-1:0] clr_q;

  logic [SIW-1:0] sat_s;
  logic [LW-1:0]  len;
  logic [12:0]    limit;
  logic [XW-1:0]  start_x, start1_x;
  logic [AW-1:0]  addr0, addr1;
  logic [7:0]     rdata;
  logic [11:0]    code_eff, entry_rd;
  logic [7:0]     nb0, nb1;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata;

  assign sat_s = (table_sectors_i > 4'(MAX_SECTORS)) ? SIW'(MAX_SECTORS)
                                                      : SIW'(table_sectors_i);
  assign len   = len_tab[sat_s];
  assign limit = cnt_tab[sat_s];

  assign start_x  = XW'(cur_q) + XW'(cur_q[11:1]);
  assign start1_x = start_x + XW'(1);
  assign addr0    = start_x[AW-1:0];
  assign addr1    = start1_x[AW-1:0];

  assign code_eff = (req_q == REQ_WRITE) ? code_q : 12'd0;
  assign entry_rd = cur_q[0] ? {rdata, b0_q[7:4]} : {rdata[3:0], b0_q};
  assign nb0 = cur_q[0] ? {code_eff[3:0], b0_q[3:0]} : code_eff[7:0];
  assign nb1 = cur_q[0] ? code_eff[11:4] : {b1_q[7:4], code_eff[11:8]};

  assign ram_we    = cmd_i.clr_wr | cmd_i.wr0 | cmd_i.wr1;
  assign ram_waddr = cmd_i.clr_wr ? clr_q : (cmd_i.wr1 ? addr1 : addr0);
  assign ram_wdata = cmd_i.clr_wr ? 8'd0 : (cmd_i.wr1 ? nb1 : nb0);
  assign ram_raddr = cmd_i.rd0 ? addr0 : addr1;

  fte_ram #(
    .WIDTH(8),
    .DEPTH(StoreBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      cur_q    <= cluster_i;
      code_q   <= code_i;
      value_q  <= 12'd0;
      status_q <= ST_OK;
      freed_q  <= 13'd0;
    end
    if (cmd_i.rd1) b0_q <= rdata;
    if (cmd_i.lat_b1) begin
      b1_q  <= rdata;
      old_q <= entry_rd;
    end
    if (cmd_i.set_value)  value_q  <= entry_rd;
    if (cmd_i.set_status) status_q <= cmd_i.status;
    if (cmd_i.step) begin
      freed_q <= freed_q + 13'd1;
      cur_q   <= old_q;
    end
    if (cmd_i.out_load) begin
      ev_q <= value_q;
      st_q <= status_q;
      fc_q <= freed_q[12] ? 12'hfff : freed_q[11:0];
    end
  end

  assign sts_o.req         = req_q;
  assign sts_o.in_range    = (CW'(start_x) + CW'(1)) < CW'(len);
  assign sts_o.below_limit = (freed_q < limit) && (limit <= CNT_CAP);
  assign sts_o.end_mark    = old_q >= END_MARK;
  assign sts_o.clr_last    = clr_q == AW'(StoreBytes - 1);

  assign entry_value_o = ev_q;
  assign status_o      = st_q;
  assign freed_count_o = fc_q;

endmodule

// ===== rtl/fat12_table_engine_unit.sv =====
// FAT12 table engine: keeps the allocation table in an on-chip byte RAM of
// SECTOR_BYTES*MAX_SECTORS bytes and serves one request at a time. After reset
// the RAM is zeroed one byte per cycle with in_stall_o high; table_sectors may
// be written meanwhile. Every byte goes through the RAM's one read port or its
// one write port, one access per cycle, so a read, a write and each freed entry
// of a chain free move their two bytes one after another; a chain free ends on
// an end marker, out of range or at the walk limit. Requests 3 give an all-zero
// result. A new request is taken while the previous result waits on
// out_stall_i.
module fat12_table_engine_unit import fte_pkg::*; #(
  parameter int SECTOR_BYTES = 512,
  parameter int MAX_SECTORS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] cluster_i,
  input  logic [11:0] code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] entry_value_o,
  output logic [1:0]  status_o,
  output logic [11:0] freed_count_o
);

  logic [3:0] table_sectors_q;
  fte_cmd_t   cmd;
  fte_sts_t   sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_sectors_q <= TABLE_SECTORS_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_TABLE_SECTORS) begin
      table_sectors_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr == ADDR_TABLE_SECTORS) ? {28'd0, table_sectors_q} : 32'd0;

  fte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fte_datapath #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_sectors_i(table_sectors_q),
    .req_type_i     (req_type_i),
    .cluster_i      (cluster_i),
    .code_i         (code_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_value_o  (entry_value_o),
    .status_o       (status_o),
    .freed_count_o  (freed_count_o)
  );

endmodule

// ===== rtl/fte_checker.sv =====
module fte_checker import fte_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] entry_value_o,
  input logic [1:0]  status_o,
  input logic [11:0] freed_count_o
);

  // one request in flight at a time
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a request is in flight");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(entry_value_o) && $stable(status_o) && $stable(freed_count_o)))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_RANGE || status_o == ST_CHAIN))
    else $error("undefined status code");

  // failed requests never report an entry
  a_error_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (entry_value_o == 12'd0))
    else $error("entry value on failed request");

endmodule

bind fat12_table_engine_unit fte_checker u_fte_checker (.*);

// ===== tb/tb_fat12_table_engine_unit.sv =====
`timescale 1ns / 100ps

module tb_fat12_table_engine_unit import fte_pkg::*;;

  localparam int SECTOR_BYTES = 512;
  localparam int MAX_SECTORS  = 8;
  localparam int STORE_BYTES  = SECTOR_BYTES * MAX_SECTORS;
  localparam int SHORT_WALK   = 48;
  localparam int CYCLE_LIMIT  = 2_500_000;

  typedef struct packed {
    logic [11:0] value;
    logic [1:0]  status;
    logic [11:0] freed;
  } fat_result_t;

  class fat12_shadow;
    logic [7:0]  table_mem [STORE_BYTES];
    logic [7:0]  scratch [STORE_BYTES];
    logic [3:0]  sectors;
    fat_result_t awaited_results [$];
    int unsigned mismatches;

    function new();
      foreach (table_mem[i]) table_mem[i] = 8'h00;
      sectors    = TABLE_SECTORS_RST;
      mismatches = 0;
    endfunction

    function void set_sectors(logic [3:0] value);
      sectors = value;
    endfunction

    function int unsigned table_len();
      int unsigned s;
      s = (sectors > MAX_SECTORS) ? MAX_SECTORS : sectors;
      return s * SECTOR_BYTES;
    endfunction

    function bit fits(int unsigned n, int unsigned len);
      return ((n * 3) >> 1) + 1 < len;
    endfunction

    function int unsigned entries(int unsigned len);
      int unsigned cnt;
      cnt = 0;
      if (len >= 2) cnt += (len - 2) / 3 + 1;
      if (len >= 3) cnt += (len - 3) / 3 + 1;
      if (cnt > CNT_CAP) cnt = CNT_CAP;
      return cnt;
    endfunction

    function int unsigned entry_total();
      return entries(table_len());
    endfunction

    function logic [11:0] fetch(int unsigned n);
      int unsigned start;
      logic [7:0]  b0, b1;
      start = (n * 3) >> 1;
      b0 = table_mem[start % STORE_BYTES];
      b1 = table_mem[(start + 1) % STORE_BYTES];
      if (n % 2 == 1) return {b1, b0[7:4]};
      return {b1[3:0], b0};
    endfunction

    function void store(int unsigned n, logic [11:0] code);
      int unsigned i0, i1;
      i0 = ((n * 3) >> 1) % STORE_BYTES;
      i1 = (((n * 3) >> 1) + 1) % STORE_BYTES;
      if (n % 2 == 1) begin
        table_mem[i0] = {code[3:0], table_mem[i0][3:0]};
        table_mem[i1] = code[11:4];
      end else begin
        table_mem[i0] = code[7:0];
        table_mem[i1] = {table_mem[i1][7:4], code[11:8]};
      end
    endfunction

    function fat_result_t serve_request(logic [1:0] req, logic [11:0] clus,
                                        logic [11:0] code);
      fat_result_t r;
      int unsigned len, limit, cur, walked;
      logic [11:0] link;
      bit          ended;
      r   = '0;
      len = table_len();
      case (req)
        REQ_READ: begin
          if (fits(clus, len)) r.value = fetch(clus);
          else r.status = ST_RANGE;
        end
        REQ_WRITE: begin
          if (fits(clus, len)) store(clus, code);
          else r.status = ST_RANGE;
        end
        REQ_FREE: begin
          limit  = entries(len);
          cur    = clus;
          walked = 0;
          ended  = 1'b0;
          while (walked < limit && !ended) begin
            if (!fits(cur, len)) begin
              r.status = ST_RANGE;
              ended    = 1'b1;
            end else begin
              link = fetch(cur);
              store(cur, 12'h000);
              walked++;
              if (link >= END_MARK) ended = 1'b1;
              else cur = link;
            end
          end
          if (!ended) r.status = ST_CHAIN;
          r.freed = (walked > 4095) ? 12'hfff : 12'(walked);
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    // dry run of a chain free, table left untouched
    function int unsigned free_cost(logic [11:0] clus);
      fat_result_t r;
      scratch = table_mem;
      r = serve_request(REQ_FREE, clus, 12'h000);
      table_mem = scratch;
      return r.freed;
    endfunction

    function void note_request(logic [1:0] req, logic [11:0] clus, logic [11:0] code);
      awaited_results.push_back(serve_request(req, clus, code));
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    endfunction

    function void check_result(logic [11:0] value, logic [1:0] status, logic [11:0] freed);
      fat_result_t want;
      if (awaited_results.size() == 0) begin
        report("result with no request pending", 0, value);
        return;
      end
      want = awaited_results.pop_front();
      if (value !== want.value) report("entry_value", want.value, value);
      if (status !== want.status) report("status", want.status, status);
      if (freed !== want.freed) report("freed_count", want.freed, freed);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  req_type_i;
  logic [11:0] cluster_i, code_i;
  logic        out_valid_o, out_stall_i;
  logic [11:0] entry_value_o;
  logic [1:0]  status_o;
  logic [11:0] freed_count_o;

  fat12_shadow shadow;
  int          items_sent = 0;
  int          long_walks_left = 10;
  bit          gaps_on = 1'b1;
  bit          pressure_hold = 1'b0;
  int          stall_left = 0;
  int          run_left = 0;
  int          cycle_count = 0;

  fat12_table_engine_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .cluster_i    (cluster_i),
    .code_i       (code_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .entry_value_o(entry_value_o),
    .status_o     (status_o),
    .freed_count_o(freed_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side stall pattern
  always @(negedge clk_i) begin
    if (pressure_hold) begin
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (run_left > 0) begin
        run_left--;
      end else begin
        stall_left = pick_gap();
        run_left   = $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      shadow.check_result(entry_value_o, status_o, freed_count_o);
  end

  // long receiver hold-offs so the engine backs up into its input
  initial begin
    wait (items_sent >= 500);
    @(posedge clk_i);
    pressure_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    pressure_hold = 1'b0;
    wait (items_sent >= 1200);
    @(posedge clk_i);
    pressure_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    pressure_hold = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task send_request(logic [1:0] req, logic [11:0] clus, logic [11:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    cluster_i  <= clus;
    code_i     <= code;
    do @(posedge clk_i); while (in_stall_o);
    shadow.note_request(req, clus, code);
    items_sent++;
  endtask

  task drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task set_table_sectors(logic [3:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TABLE_SECTORS;
    pwdata  <= {28'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow.set_sectors(value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {28'd0, value}) shadow.report("table_sectors readback", value, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // long walks are rare, most turn into reads of the same entry
  task free_guarded(logic [11:0] clus, logic [11:0] code);
    int unsigned walk;
    walk = shadow.free_cost(clus);
    if (walk <= SHORT_WALK || (long_walks_left > 0 && $urandom_range(0, 3) == 0)) begin
      if (walk > SHORT_WALK) long_walks_left--;
      send_request(REQ_FREE, clus, code);
    end else begin
      send_request(REQ_READ, clus, code);
    end
  endtask

  task noise_request();
    logic [1:0]  req;
    logic [11:0] clus, code;
    int unsigned total;
    int          r;
    total = shadow.entry_total();
    req   = 2'($urandom_range(0, 3));
    r     = $urandom_range(0, 9);
    if (total > 0 && r < 6) clus = 12'($urandom_range(0, total - 1));
    else if (total > 0 && r < 8) clus = 12'(total - 1 + $urandom_range(0, 1));
    else clus = 12'($urandom);
    if ($urandom_range(0, 3) == 0) code = END_MARK | 12'($urandom_range(0, 7));
    else code = 12'($urandom);
    if (req == REQ_FREE) free_guarded(clus, code);
    else send_request(req, clus, code);
  endtask

  // link a short chain, read some of it back, then free it
  task chain_sequence();
    logic [11:0] links [9];
    int unsigned total, len, pick;
    total = shadow.entry_total();
    if (total < 2) begin
      noise_request();
      return;
    end
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) links[i] = 12'($urandom_range(0, total - 1));
    pick = $urandom_range(0, 9);
    if (pick < 8) links[len] = END_MARK | 12'($urandom_range(0, 7));
    else if (pick == 8) links[len] = 12'($urandom_range(total, 4095));
    else links[len] = 12'($urandom_range(0, total - 1));
    for (int i = 0; i < len; i++) begin
      send_request(REQ_WRITE, links[i], links[i + 1]);
      if ($urandom_range(0, 5) == 0) noise_request();
    end
    repeat ($urandom_range(0, 2))
      send_request(REQ_READ, links[$urandom_range(0, len - 1)], 12'($urandom));
    free_guarded(links[0], 12'($urandom));
  endtask

  task run_phase(logic [3:0] sectors, int count);
    int stop_at;
    drain_requests();
    set_table_sectors(sectors);
    gaps_on = ($urandom_range(0, 3) != 0);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 55) chain_sequence();
      else noise_request();
    end
  endtask

  initial begin
    shadow      = new();
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = ADDR_TABLE_SECTORS;
    pwdata      = 32'd0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_NONE;
    cluster_i   = 12'd0;
    code_i      = 12'd0;
    out_stall_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full table: nibble sharing, range edges, idle request, short chains
    set_table_sectors(4'd8);
    send_request(REQ_WRITE, 12'd0, 12'hfff);
    send_request(REQ_WRITE, 12'd1, 12'habc);
    send_request(REQ_READ, 12'd0, 12'h000);
    send_request(REQ_READ, 12'd1, 12'h000);
    send_request(REQ_WRITE, 12'd2729, 12'h5a5);
    send_request(REQ_READ, 12'd2729, 12'h000);
    send_request(REQ_WRITE, 12'd2730, 12'h123);
    send_request(REQ_READ, 12'd2730, 12'h000);
    send_request(REQ_READ, 12'hfff, 12'h000);
    send_request(REQ_NONE, 12'hfff, 12'hfff);
    send_request(REQ_WRITE, 12'd5, 12'd7);
    send_request(REQ_WRITE, 12'd7, END_MARK);
    send_request(REQ_FREE, 12'd5, 12'h000);
    send_request(REQ_READ, 12'd7, 12'h000);
    send_request(REQ_WRITE, 12'd20, 12'd3000);
    send_request(REQ_FREE, 12'd20, 12'h000);

    // one sector: a loop through entry zero runs into the walk limit
    drain_requests();
    set_table_sectors(4'd1);
    send_request(REQ_WRITE, 12'd0, 12'h000);
    send_request(REQ_WRITE, 12'd3, 12'd3);
    send_request(REQ_FREE, 12'd3, 12'h000);
    send_request(REQ_WRITE, 12'd340, 12'hfff);
    send_request(REQ_READ, 12'd340, 12'h000);
    send_request(REQ_READ, 12'd341, 12'h000);

    // empty table
    drain_requests();
    set_table_sectors(4'd0);
    send_request(REQ_READ, 12'd0, 12'h000);
    send_request(REQ_FREE, 12'd0, 12'h000);
    send_request(REQ_WRITE, 12'd0, 12'hfff);

    run_phase(4'd15, 260);
    run_phase(4'd2, 260);
    run_phase(4'd8, 280);
    run_phase(4'd0, 40);
    run_phase(4'd1, 250);
    run_phase(4'd5, 250);
    run_phase(4'd3, 240);

    drain_requests();
    repeat (16) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fte_pkg.sv
rtl/fte_ram.sv
rtl/fte_ctrl.sv
rtl/fte_datapath.sv
rtl/fat12_table_engine_unit.sv
rtl/fte_checker.sv
tb/tb_fat12_table_engine_unit.sv
